/* rtl/rrts_pkg.sv */
package rrts_pkg;

  // Thread ids
  localparam int unsigned ID_W = 8;

  // Ready queue geometry
  localparam int unsigned READY_DEPTH = 16;
  localparam int unsigned RQ_AW = $clog2(READY_DEPTH);
  localparam int unsigned RQ_CW = $clog2(READY_DEPTH + 1);

  // Semaphore wait queue geometry
  localparam int unsigned WAIT_DEPTH = 16;
  localparam int unsigned WQ_AW = $clog2(WAIT_DEPTH);
  localparam int unsigned WQ_CW = $clog2(WAIT_DEPTH + 1);

  // Semaphore counter, two's complement, saturates at the top
  localparam int unsigned SEM_W = 16;
  localparam logic [SEM_W-1:0] SEM_MAX = 16'h7FFF;

  // Result field widths
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned RCOUNT_W = 5;
  localparam int unsigned KIND_W = 3;

  // Configuration port
  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned INIT_W = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_YIELD     = 3'd0,
    KIND_CREATE    = 3'd1,
    KIND_TERMINATE = 3'd2,
    KIND_SEM_WAIT  = 3'd3,
    KIND_SEM_POST  = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_e;

  // Semaphore setup request from the register block
  typedef struct packed {
    logic              load;
    logic [INIT_W-1:0] value;
  } cfg_t;

endpackage

/* rtl/rrts_regfile.sv */
module rrts_regfile import rrts_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  logic [ID_W-1:0] wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output logic [ID_W-1:0] rdata_o
);

  logic [ID_W-1:0] mem_q [DEPTH];
  logic [ID_W-1:0] rdata_q;

  // Single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read of the head slot after this edge; a write to it passes through
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rrts_cfg.sv */
module rrts_cfg import rrts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  logic [INIT_W-1:0] init_q;
  logic              wr_en;

  // Only one register: every address decodes to the semaphore count
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = PDATA_W'(init_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
    end else if (wr_en) begin
      init_q <= pwdata[INIT_W-1:0];
    end
  end

  // Setup request: reload counter and flush waiters
  assign cfg_o.load  = wr_en && (paddr == '0 || paddr != '0);
  assign cfg_o.value = pwdata[INIT_W-1:0];

endmodule

/* rtl/round_robin_thread_scheduler_semaphore.sv */
// Round-robin thread scheduler with one counting semaphore.
// Input channel (in_valid_i/in_ready_o): one event per request, kind_i selects
// yield, create, terminate, semaphore wait or semaphore signal; new_thread_id_i
// is used by create only.
// Output channel (out_valid_o/out_ready_i): one result per event with the
// running thread id, whether a thread runs, a status code and the ready
// queue fill level after the event.
// The result is registered and presented in the cycle after the event is taken.
// Throughput: one event per cycle when not stalled; all state (queue heads,
// tails, counts and the semaphore counter) is updated in the accepting cycle,
// queue head entries are held in registers read ahead from small register files.
// Stall: while a result waits and out_ready_i is low, in_ready_o is low; a
// result taken in the same cycle lets a new event in.
// Reset: thread 0 runs, both queues are empty, the semaphore count and its
// register are zero. An APB write sets the count and empties the wait queue;
// write it only while no event is in flight.
module round_robin_thread_scheduler_semaphore import rrts_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [ID_W-1:0]     new_thread_id_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ID_W-1:0]     running_id_o,
  output logic                running_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [RCOUNT_W-1:0] ready_count_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  cfg_t cfg;

  // Scheduler state
  logic [ID_W-1:0]  run_q, run_d;
  logic             pres_q, pres_d;
  logic [RQ_AW-1:0] rq_head_q, rq_head_d;
  logic [RQ_CW-1:0] rq_cnt_q, rq_cnt_d;
  logic [WQ_AW-1:0] wq_head_q, wq_head_d;
  logic [WQ_CW-1:0] wq_cnt_q, wq_cnt_d;
  logic [SEM_W-1:0] sem_q, sem_d;

  // Result register
  logic                out_valid_q;
  logic [ID_W-1:0]     res_id_q;
  logic                res_valid_q;
  status_e             res_status_q, status;
  logic [RCOUNT_W-1:0] res_count_q;

  logic accept;

  // Queue access
  logic             rq_push, rq_pop, wq_push, wq_pop;
  logic [ID_W-1:0]  rq_wdata, rq_rdata, wq_rdata;
  logic [RQ_AW:0]   rq_sum;
  logic [WQ_AW:0]   wq_sum;
  logic [RQ_AW-1:0] rq_tail, rq_raddr;
  logic [WQ_AW-1:0] wq_tail, wq_raddr;
  logic             rq_full, rq_empty, wq_full, wq_empty;
  logic             sem_le0, sem_neg;

  rrts_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .cfg_o (cfg)
  );

  rrts_regfile #(.DEPTH(READY_DEPTH)) u_ready_q (
    .clk_i,
    .we_i    (accept && rq_push),
    .waddr_i (rq_tail),
    .wdata_i (rq_wdata),
    .raddr_i (rq_raddr),
    .rdata_o (rq_rdata)
  );

  rrts_regfile #(.DEPTH(WAIT_DEPTH)) u_wait_q (
    .clk_i,
    .we_i    (accept && wq_push),
    .waddr_i (wq_tail),
    .wdata_i (run_q),
    .raddr_i (wq_raddr),
    .rdata_o (wq_rdata)
  );

  // Head slots as they stand after this edge
  assign rq_raddr = accept ? rq_head_d : rq_head_q;
  assign wq_raddr = cfg.load ? '0 : (accept ? wq_head_d : wq_head_q);

  // Handshake: a waiting result blocks input unless it leaves this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Tail positions, wrapped at the queue depth
  always_comb begin
    rq_sum = (RQ_AW+1)'(rq_head_q) + (RQ_AW+1)'(rq_cnt_q);
    if (rq_sum >= (RQ_AW+1)'(READY_DEPTH)) begin
      rq_sum = rq_sum - (RQ_AW+1)'(READY_DEPTH);
    end
    rq_tail = rq_sum[RQ_AW-1:0];
    wq_sum = (WQ_AW+1)'(wq_head_q) + (WQ_AW+1)'(wq_cnt_q);
    if (wq_sum >= (WQ_AW+1)'(WAIT_DEPTH)) begin
      wq_sum = wq_sum - (WQ_AW+1)'(WAIT_DEPTH);
    end
    wq_tail = wq_sum[WQ_AW-1:0];
  end

  assign rq_full  = (rq_cnt_q == RQ_CW'(READY_DEPTH));
  assign rq_empty = (rq_cnt_q == '0);
  assign wq_full  = (wq_cnt_q == WQ_CW'(WAIT_DEPTH));
  assign wq_empty = (wq_cnt_q == '0);
  assign sem_neg  = sem_q[SEM_W-1];
  assign sem_le0  = sem_neg || (sem_q == '0);

  // Event decode and next state
  always_comb begin
    run_d    = run_q;
    pres_d   = pres_q;
    sem_d    = sem_q;
    status   = ST_OK;
    rq_push  = 1'b0;
    rq_pop   = 1'b0;
    rq_wdata = new_thread_id_i;
    wq_push  = 1'b0;
    wq_pop   = 1'b0;
    case (kind_e'(kind_i))
      KIND_YIELD: begin
        if (!rq_empty) begin
          run_d    = rq_rdata;
          pres_d   = 1'b1;
          rq_pop   = 1'b1;
          rq_push  = pres_q;
          rq_wdata = run_q;
        end
      end
      KIND_CREATE: begin
        if (rq_full) begin
          status = ST_FULL;
        end else begin
          rq_push = 1'b1;
        end
      end
      KIND_TERMINATE: begin
        if (rq_empty) begin
          pres_d = 1'b0;
          run_d  = '0;
          status = ST_NONE;
        end else begin
          run_d  = rq_rdata;
          pres_d = 1'b1;
          rq_pop = 1'b1;
        end
      end
      KIND_SEM_WAIT: begin
        if (!pres_q) begin
          status = ST_NONE;
        end else if (sem_le0) begin
          if (wq_full) begin
            status = ST_FULL;
          end else begin
            sem_d   = sem_q - SEM_W'(1);
            wq_push = 1'b1;
            // park the caller and run the next ready thread
            if (rq_empty) begin
              pres_d = 1'b0;
              run_d  = '0;
              status = ST_NONE;
            end else begin
              run_d  = rq_rdata;
              pres_d = 1'b1;
              rq_pop = 1'b1;
            end
          end
        end else begin
          sem_d = sem_q - SEM_W'(1);
        end
      end
      KIND_SEM_POST: begin
        if (sem_neg && !wq_empty) begin
          if (rq_full) begin
            status = ST_FULL;
          end else begin
            sem_d    = sem_q + SEM_W'(1);
            wq_pop   = 1'b1;
            rq_push  = 1'b1;
            rq_wdata = wq_rdata;
          end
        end else if (sem_q != SEM_MAX) begin
          sem_d = sem_q + SEM_W'(1);
        end
      end
      default: begin
      end
    endcase

    // Pointer and fill updates
    rq_head_d = rq_head_q;
    if (rq_pop) begin
      rq_head_d = (rq_head_q == RQ_AW'(READY_DEPTH - 1)) ? '0 : rq_head_q + RQ_AW'(1);
    end
    rq_cnt_d = rq_cnt_q + RQ_CW'(rq_push) - RQ_CW'(rq_pop);

    wq_head_d = wq_head_q;
    if (wq_pop) begin
      wq_head_d = (wq_head_q == WQ_AW'(WAIT_DEPTH - 1)) ? '0 : wq_head_q + WQ_AW'(1);
    end
    wq_cnt_d = wq_cnt_q + WQ_CW'(wq_push) - WQ_CW'(wq_pop);
  end

  // State and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      pres_q      <= 1'b1;
      rq_head_q   <= '0;
      rq_cnt_q    <= '0;
      wq_head_q   <= '0;
      wq_cnt_q    <= '0;
      sem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg.load) begin
        sem_q     <= SEM_W'(cfg.value);
        wq_head_q <= '0;
        wq_cnt_q  <= '0;
      end else if (accept) begin
        sem_q     <= sem_d;
        wq_head_q <= wq_head_d;
        wq_cnt_q  <= wq_cnt_d;
      end
      if (accept) begin
        run_q     <= run_d;
        pres_q    <= pres_d;
        rq_head_q <= rq_head_d;
        rq_cnt_q  <= rq_cnt_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_id_q     <= pres_d ? run_d : '0;
      res_valid_q  <= pres_d;
      res_status_q <= status;
      res_count_q  <= RCOUNT_W'(rq_cnt_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign running_id_o    = res_id_q;
  assign running_valid_o = res_valid_q;
  assign status_o        = res_status_q;
  assign ready_count_o   = res_count_q;

`ifndef SYNTHESIS
  a_rq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_cnt_q <= RQ_CW'(READY_DEPTH))
    else $error("ready queue count over depth");

  a_wq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wq_cnt_q <= WQ_CW'(WAIT_DEPTH))
    else $error("wait queue count over depth");

  a_sem_waiters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sem_neg |-> (SEM_W'(wq_cnt_q) == SEM_W'(-sem_q)))
    else $error("waiter count does not match negative semaphore");

  a_sem_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sem_neg |-> wq_empty)
    else $error("waiters present with nonnegative semaphore");

  a_idle_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pres_q |-> (run_q == '0))
    else $error("stale thread id with no thread running");
`endif

endmodule

/* tb/round_robin_thread_scheduler_semaphore_tb.sv */
`timescale 1ns / 100ps

module round_robin_thread_scheduler_semaphore_tb;
  import rrts_pkg::*;

  localparam logic [PADDR_W-1:0] SEM_INIT_ADDR = '0;
  localparam int unsigned        IDLE_PCT      = 31;
  localparam int unsigned        BURST_SIGNALS = 40;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   tid;
  } sched_req_t;

  typedef struct {
    logic [ID_W-1:0]     run_id;
    logic                run_on;
    status_e             st;
    logic [RCOUNT_W-1:0] rcnt;
  } sched_res_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // DUT ports
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   kind = KIND_YIELD;
  logic [ID_W-1:0]     tid = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ID_W-1:0]     running_id;
  logic                running_valid;
  logic [STATUS_W-1:0] status;
  logic [RCOUNT_W-1:0] ready_count;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  round_robin_thread_scheduler_semaphore dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .kind_i          (kind),
    .new_thread_id_i (tid),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .running_id_o    (running_id),
    .running_valid_o (running_valid),
    .status_o        (status),
    .ready_count_o   (ready_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Scheduler shadow state
  logic [ID_W-1:0] run_id = '0;
  logic            run_on = 1'b1;
  logic [ID_W-1:0] ready_ids[$];
  logic [ID_W-1:0] parked_ids[$];
  int              sem_level = 0;
  int              sem_peak = 0;

  sched_req_t req_backlog[$];
  sched_res_t sched_due[$];

  bit calm = 1'b0;
  int errs = 0;
  int n_req = 0;
  int n_res = 0;
  int n_full = 0;
  int n_none = 0;
  int n_setups = 0;

  // Dispatch the ready head, or leave the core empty
  function automatic status_e run_head();
    if (ready_ids.size() == 0) begin
      run_on = 1'b0;
      run_id = '0;
      return ST_NONE;
    end
    run_id = ready_ids.pop_front();
    run_on = 1'b1;
    return ST_OK;
  endfunction

  // Apply one scheduler event to the shadow state and form its result
  function automatic sched_res_t sched_step(input logic [KIND_W-1:0] k,
                                            input logic [ID_W-1:0] id);
    sched_res_t r;
    logic [ID_W-1:0] prev;
    logic had;
    status_e st;
    st = ST_OK;
    case (k)
      KIND_YIELD: begin
        if (ready_ids.size() != 0) begin
          prev = run_id;
          had = run_on;
          run_id = ready_ids.pop_front();
          run_on = 1'b1;
          if (had) ready_ids.push_back(prev);
        end
      end
      KIND_CREATE: begin
        if (ready_ids.size() >= READY_DEPTH) st = ST_FULL;
        else ready_ids.push_back(id);
      end
      KIND_TERMINATE: begin
        st = run_head();
      end
      KIND_SEM_WAIT: begin
        if (!run_on) begin
          st = ST_NONE;
        end else if (sem_level - 1 < 0) begin
          // must block: park the caller unless the wait list is full
          if (parked_ids.size() >= WAIT_DEPTH) begin
            st = ST_FULL;
          end else begin
            sem_level--;
            parked_ids.push_back(run_id);
            st = run_head();
          end
        end else begin
          sem_level--;
        end
      end
      KIND_SEM_POST: begin
        if (sem_level + 1 <= 0 && parked_ids.size() != 0) begin
          // wake the oldest waiter unless the ready list is full
          if (ready_ids.size() >= READY_DEPTH) begin
            st = ST_FULL;
          end else begin
            sem_level++;
            ready_ids.push_back(parked_ids.pop_front());
          end
        end else if (sem_level < int'(SEM_MAX)) begin
          sem_level++;
        end
      end
      default: ;
    endcase
    if (sem_level > sem_peak) sem_peak = sem_level;
    r.run_id = run_on ? run_id : '0;
    r.run_on = run_on;
    r.st = st;
    r.rcnt = RCOUNT_W'(ready_ids.size());
    return r;
  endfunction

  // Request driver
  always @(posedge clk or negedge rst_ni) begin : drv
    sched_req_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        sched_due.push_back(sched_step(kind, tid));
        n_req++;
      end
      if (!in_valid || in_ready) begin
        if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = req_backlog.pop_front();
          in_valid <= 1'b1;
          kind <= nxt.kind;
          tid <= nxt.tid;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and checker
  always @(posedge clk or negedge rst_ni) begin : mon
    sched_res_t e;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (sched_due.size() == 0) begin
          $error("result with nothing expected: id %0d valid %0d status %0d count %0d",
                 running_id, running_valid, status, ready_count);
          errs++;
        end else begin
          e = sched_due.pop_front();
          n_res++;
          if (e.st == ST_FULL) n_full++;
          if (e.st == ST_NONE) n_none++;
          if (running_id !== e.run_id) begin
            $error("running_id: expected %0d, got %0d", e.run_id, running_id);
            errs++;
          end
          if (running_valid !== e.run_on) begin
            $error("running_valid: expected %0d, got %0d", e.run_on, running_valid);
            errs++;
          end
          if (status !== e.st) begin
            $error("status: expected %0d, got %0d", e.st, status);
            errs++;
          end
          if (ready_count !== e.rcnt) begin
            $error("ready_count: expected %0d, got %0d", e.rcnt, ready_count);
            errs++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic add_req(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] id);
    sched_req_t q;
    q.kind = k;
    q.tid = id;
    req_backlog.push_back(q);
  endtask

  // Wait until every request has been taken and answered
  task automatic wait_idle();
    do @(negedge clk);
    while (req_backlog.size() != 0 || in_valid || sched_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Semaphore setup over APB, only while the scheduler is idle
  task automatic sem_setup(input logic [INIT_W-1:0] v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= SEM_INIT_ADDR;
    pwdata <= PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sem_level = int'(v);
    parked_ids.delete();
    n_setups++;
    @(negedge clk);
  endtask

  // Random traffic built from short sequences that fill, park, wake and rotate
  task automatic add_traffic(input int n_target);
    int n;
    int cnt;
    int pick;
    n = 0;
    while (n < n_target) begin
      pick = $urandom_range(0, 9);
      cnt = $urandom_range(1, 20);
      for (int i = 0; i < cnt; i++) begin
        case (pick)
          0, 1, 2: add_req(KIND_CREATE, ID_W'($urandom));
          3, 4:    add_req(KIND_SEM_WAIT, ID_W'($urandom));
          5, 6:    add_req(KIND_SEM_POST, ID_W'($urandom));
          7:       add_req($urandom_range(3) == 0 ? KIND_TERMINATE : KIND_YIELD,
                           ID_W'($urandom));
          8:       add_req(KIND_W'($urandom_range(0, 7)), ID_W'($urandom));
          default: add_req(KIND_W'($urandom_range(0, 4)), ID_W'($urandom));
        endcase
      end
      n += cnt;
    end
  endtask

  initial begin : timeout
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stim
    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // Directed: empty yield, unknown kinds, id extremes, wait/park/wake,
    // draining the core, and events while no thread runs
    add_req(KIND_YIELD, 8'h00);
    add_req(3'd5, 8'hFF);
    add_req(3'd6, 8'h00);
    add_req(3'd7, 8'hFF);
    add_req(KIND_CREATE, 8'h00);
    add_req(KIND_CREATE, 8'hFF);
    add_req(KIND_YIELD, 8'h12);
    add_req(KIND_SEM_POST, 8'h00);
    add_req(KIND_SEM_WAIT, 8'h00);
    add_req(KIND_SEM_WAIT, 8'h00);
    add_req(KIND_SEM_POST, 8'h00);
    add_req(KIND_SEM_POST, 8'h00);
    repeat (4) add_req(KIND_TERMINATE, 8'h00);
    add_req(KIND_SEM_WAIT, 8'h00);
    add_req(KIND_SEM_POST, 8'h00);
    add_req(KIND_TERMINATE, 8'h00);
    add_req(KIND_CREATE, 8'h5A);
    add_req(KIND_CREATE, 8'hA5);
    add_req(KIND_YIELD, 8'h00);
    add_req(KIND_TERMINATE, 8'h00);
    add_req(KIND_TERMINATE, 8'h00);
    add_req(KIND_CREATE, 8'h33);
    add_req(KIND_TERMINATE, 8'h00);
    wait_idle();

    // Random traffic under several semaphore settings
    sem_setup(8'hFF);
    add_traffic(200);
    wait_idle();
    sem_setup(8'h00);
    add_traffic(250);
    wait_idle();
    sem_setup(INIT_W'($urandom_range(1, 254)));
    add_traffic(200);
    wait_idle();
    sem_setup(8'h01);
    add_traffic(150);
    wait_idle();

    // Back-to-back signals and waits with no idling on either side
    calm = 1'b1;
    sem_setup(8'hFF);
    repeat (BURST_SIGNALS) add_req(KIND_SEM_POST, ID_W'($urandom));
    repeat (10) add_req(KIND_SEM_WAIT, ID_W'($urandom));
    repeat (5) add_req(KIND_SEM_POST, ID_W'($urandom));
    wait_idle();
    calm = 1'b0;

    repeat (5) @(posedge clk);
    if (sched_due.size() != 0) begin
      $error("%0d expected results never arrived", sched_due.size());
      errs++;
    end
    $display("Ran %0d scheduler requests (%0d results checked) over %0d semaphore setups",
             n_req, n_res, n_setups);
    $display("Queue-full drops: %0d, no-thread outcomes: %0d, peak semaphore count: %0d",
             n_full, n_none, sem_peak);
    if (errs == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/rrts_pkg.sv
rtl/rrts_regfile.sv
rtl/rrts_cfg.sv
rtl/round_robin_thread_scheduler_semaphore.sv
tb/round_robin_thread_scheduler_semaphore_tb.sv
